FILE: design/sst_pkg.sv
// Shared constants for the sparse segment tree block.
package sst_pkg;

  localparam int POOL_DEPTH_DEF = 4096;
  localparam int KEY_BITS_DEF   = 31;

  // Empty-range sentinels
  localparam logic signed [63:0] INF_VAL = 64'sh3f3f3f3f3f3f3f3f;
  localparam logic signed [63:0] NEG_INF = -64'sh3f3f3f3f3f3f3f3f;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  localparam int RANGE_LOW_RST  = 1;
  localparam int RANGE_HIGH_RST = 1000000000;

endpackage

FILE: design/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sparse_segment_tree_sum_max_min.sv
// Sparse segment tree: point add and range sum/max/min query, sequenced over node RAM.
// Add: walks down the existing levels, counts the missing levels and allocates one node
//   per missing level, then recomputes each level on the way up.
// Query: each visited node is popped, read and evaluated; up to 4 nodes per level.
// One item at a time: busy is high until the done strobe; results cannot be stalled.
// Reset (sync, rst high) empties the tree at once (fill count); no clearing pass.
module sparse_segment_tree_sum_max_min #(
  parameter int POOL_DEPTH = sst_pkg::POOL_DEPTH_DEF,
  parameter int KEY_BITS   = sst_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic signed [KEY_BITS-1:0] position,
  input  logic signed [31:0]         delta,
  input  logic signed [KEY_BITS-1:0] query_low,
  input  logic signed [KEY_BITS-1:0] query_high,
  output logic                       done,
  output logic                       status,
  output logic signed [63:0]         range_sum,
  output logic signed [62:0]         range_max,
  output logic signed [62:0]         range_min,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [KEY_BITS-1:0]        cfg_data
);
  import sst_pkg::*;

  localparam int ID_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W     = ID_W + 1;
  localparam int LEVELS    = KEY_BITS;
  localparam int PIDX_W    = $clog2(LEVELS);
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int STK_DEPTH = 2 * KEY_BITS + 4;
  localparam int SA_W      = $clog2(STK_DEPTH);
  localparam int SP_W      = $clog2(STK_DEPTH + 1);
  localparam int NODE_W    = 2 * ID_W + 2 * KEY_BITS + 3 * 64;
  localparam logic [CNT_W:0] POOL_LIM = (CNT_W + 1)'(POOL_DEPTH);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_D_ISSUE = 15'h0002,
    S_D_STEP  = 15'h0004,
    S_COUNT   = 15'h0008,
    S_CHECK   = 15'h0010,
    S_LINK    = 15'h0020,
    S_ALLOC   = 15'h0040,
    S_L_ADD   = 15'h0080,
    S_U_ISSUE = 15'h0100,
    S_U_NODE  = 15'h0200,
    S_U_SIB   = 15'h0400,
    S_Q_POP   = 15'h0800,
    S_Q_SRD   = 15'h1000,
    S_Q_EVAL  = 15'h2000,
    S_Q_PUSH2 = 15'h4000
  } state_t;

  state_t state;

  // Control and configuration
  logic signed [KEY_BITS-1:0] range_low, range_high, root_hi;
  logic [CNT_W-1:0]           nodes_used;
  logic                       root_written;
  logic [LVL_W-1:0]           len, need;
  logic [SP_W-1:0]            sp;

  // Walk registers
  logic signed [KEY_BITS-1:0] p, lo, hi, brk_lo, brk_hi, ql, qr;
  logic [ID_W-1:0]            cur, rd_id, h_id, pend;
  logic [ID_W-1:0]            path [LEVELS];
  logic [LEVELS-1:0]          pdir;
  logic                       h_dir;
  logic [ID_W-1:0]            h_lc, h_rc;
  logic signed [KEY_BITS-1:0] h_klo, h_khi;
  logic signed [63:0]         d64, cur_sum, cur_max, cur_min;
  logic signed [63:0]         acc_sum, acc_max, acc_min;

  // Node RAM ports
  logic              n_we;
  logic [ID_W-1:0]   n_waddr, n_raddr;
  logic [NODE_W-1:0] n_wdata, n_rdata;
  logic [ID_W-1:0]   w_lc, w_rc;
  logic signed [KEY_BITS-1:0] w_klo, w_khi;
  logic signed [63:0] w_sum, w_max, w_min;

  // Raw and corrected read fields
  logic [ID_W-1:0]            r_lc, r_rc, n_lc, n_rc;
  logic signed [KEY_BITS-1:0] r_klo, r_khi, n_klo, n_khi;
  logic signed [63:0]         r_sum, r_max, r_min, n_sum, n_max, n_min;

  // Stack RAM ports
  logic            s_we;
  logic [SA_W-1:0] s_waddr, s_raddr;
  logic [ID_W-1:0] s_wdata, s_rdata;

  logic signed [KEY_BITS-1:0] p_clamp, mid_w, mid_n, lo_nx, hi_nx;
  logic signed [KEY_BITS:0]   sum_w, sum_n;
  logic                       go_right, leaf_w, pool_full;
  logic [ID_W-1:0]            child_sel, other, k_id, k_next;
  logic [PIDX_W-1:0]          ptop, pcur;
  logic                       q_out, q_cov, q_leaf, q_split, q_pl, q_pr, sib_use;
  logic signed [63:0]         c_sum, c_max, c_min, m1, n1;

  sst_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  sst_ram #(.WIDTH(ID_W), .DEPTH(STK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign {r_lc, r_rc, r_klo, r_khi, r_sum, r_max, r_min} = n_rdata;
  assign n_wdata = {w_lc, w_rc, w_klo, w_khi, w_sum, w_max, w_min};

  // Key arithmetic and node correction
  always_comb begin
    root_hi  = (range_high < range_low) ? range_low : range_high;
    p_clamp  = position;
    if (position < range_low) p_clamp = range_low;
    if (position > root_hi) p_clamp = root_hi;
    sum_w    = {lo[KEY_BITS-1], lo} + {hi[KEY_BITS-1], hi};
    mid_w    = sum_w[KEY_BITS:1];
    go_right = (p > mid_w);
    lo_nx    = go_right ? mid_w + 1'b1 : lo;
    hi_nx    = go_right ? hi : mid_w;
    leaf_w   = !(lo < hi);
    ptop     = PIDX_W'(len - 1'b1);
    pcur     = PIDX_W'(len);
    k_id     = nodes_used[ID_W-1:0];
    k_next   = k_id + 1'b1;
    pool_full = ({1'b0, nodes_used} + (CNT_W + 1)'(need)) > POOL_LIM;

    // root keys live in registers; an unwritten root reads empty
    n_lc  = r_lc;
    n_rc  = r_rc;
    n_klo = r_klo;
    n_khi = r_khi;
    n_sum = r_sum;
    n_max = r_max;
    n_min = r_min;
    if (rd_id == '0) begin
      n_klo = range_low;
      n_khi = root_hi;
      if (!root_written) begin
        n_lc  = '0;
        n_rc  = '0;
        n_sum = '0;
        n_max = '0;
        n_min = '0;
      end
    end
    child_sel = go_right ? n_rc : n_lc;
    other     = pdir[ptop] ? n_lc : n_rc;

    // query classification
    sum_n   = {n_klo[KEY_BITS-1], n_klo} + {n_khi[KEY_BITS-1], n_khi};
    mid_n   = sum_n[KEY_BITS:1];
    q_out   = (qr < n_klo) || (ql > n_khi);
    q_cov   = (ql <= n_klo) && (n_khi <= qr);
    q_leaf  = !(n_klo < n_khi);
    q_split = !q_out && !q_cov && !q_leaf;
    q_pl    = (ql <= mid_n) && (n_lc != '0);
    q_pr    = (qr > mid_n) && (n_rc != '0);

    // recompute from on-path child plus optional sibling
    sib_use = (state == S_U_SIB);
    c_sum   = cur_sum + (sib_use ? n_sum : 64'sd0);
    m1      = (cur_max >= NEG_INF) ? cur_max : NEG_INF;
    c_max   = (sib_use && n_max > m1) ? n_max : m1;
    n1      = (cur_min <= INF_VAL) ? cur_min : INF_VAL;
    c_min   = (sib_use && n_min < n1) ? n_min : n1;
  end

  // Memory access steering
  always_comb begin
    n_raddr = '0;
    n_we    = 1'b0;
    n_waddr = '0;
    w_lc    = '0;
    w_rc    = '0;
    w_klo   = lo;
    w_khi   = hi;
    w_sum   = '0;
    w_max   = '0;
    w_min   = '0;
    s_we    = 1'b0;
    s_waddr = sp[SA_W-1:0];
    s_wdata = '0;
    s_raddr = SA_W'(sp - 1'b1);
    case (state)
      S_D_ISSUE, S_CHECK: n_raddr = cur;
      S_U_ISSUE: n_raddr = path[ptop];
      S_U_NODE: begin
        n_raddr = other;
        if (other == '0) begin
          n_we    = 1'b1;
          n_waddr = rd_id;
          w_lc    = n_lc;
          w_rc    = n_rc;
          w_klo   = n_klo;
          w_khi   = n_khi;
          w_sum   = c_sum;
          w_max   = c_max;
          w_min   = c_min;
        end
      end
      S_U_SIB: begin
        n_we    = 1'b1;
        n_waddr = h_id;
        w_lc    = h_lc;
        w_rc    = h_rc;
        w_klo   = h_klo;
        w_khi   = h_khi;
        w_sum   = c_sum;
        w_max   = c_max;
        w_min   = c_min;
      end
      S_LINK: begin
        n_we    = 1'b1;
        n_waddr = h_id;
        w_lc    = h_dir ? h_lc : k_id;
        w_rc    = h_dir ? k_id : h_rc;
        w_klo   = h_klo;
        w_khi   = h_khi;
        w_sum   = cur_sum;
        w_max   = cur_max;
        w_min   = cur_min;
      end
      S_ALLOC: begin
        n_we    = 1'b1;
        n_waddr = k_id;
        if (!leaf_w) begin
          w_lc = go_right ? '0 : k_next;
          w_rc = go_right ? k_next : '0;
        end else begin
          w_sum = d64;
          w_max = d64;
          w_min = d64;
        end
      end
      S_L_ADD: begin
        n_we    = 1'b1;
        n_waddr = rd_id;
        w_lc    = n_lc;
        w_rc    = n_rc;
        w_klo   = n_klo;
        w_khi   = n_khi;
        w_sum   = n_sum + d64;
        w_max   = n_max + d64;
        w_min   = n_min + d64;
      end
      S_IDLE: begin
        s_we = start && (mode == MODE_QUERY) && !(query_low > query_high);
      end
      S_Q_SRD: n_raddr = s_rdata;
      S_Q_EVAL: begin
        s_we    = q_split && (q_pl || q_pr);
        s_wdata = q_pl ? n_lc : n_rc;
      end
      S_Q_PUSH2: begin
        s_we    = 1'b1;
        s_wdata = pend;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      done         <= 1'b0;
      nodes_used   <= CNT_W'(1);
      root_written <= 1'b0;
      range_low    <= KEY_BITS'(RANGE_LOW_RST);
      range_high   <= KEY_BITS'(RANGE_HIGH_RST);
      len          <= '0;
      sp           <= '0;
    end else begin
      done  <= 1'b0;
      rd_id <= n_raddr;
      if (n_we && n_waddr == '0) root_written <= 1'b1;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            d64  <= {{32{delta[31]}}, delta};
            if (mode == MODE_ADD) begin
              p     <= p_clamp;
              lo    <= range_low;
              hi    <= root_hi;
              cur   <= '0;
              len   <= '0;
              need  <= '0;
              state <= S_D_ISSUE;
            end else begin
              ql      <= query_low;
              qr      <= query_high;
              acc_sum <= '0;
              acc_max <= NEG_INF;
              acc_min <= INF_VAL;
              if (query_low > query_high) begin
                busy      <= 1'b0;
                done      <= 1'b1;
                status    <= STATUS_OK;
                range_sum <= '0;
                range_max <= NEG_INF[62:0];
                range_min <= INF_VAL[62:0];
              end else begin
                sp    <= SP_W'(1);
                state <= S_Q_POP;
              end
            end
          end
        end
        S_D_ISSUE: state <= leaf_w ? S_CHECK : S_D_STEP;
        S_D_STEP: begin
          path[pcur] <= cur;
          pdir[pcur] <= go_right;
          len        <= len + 1'b1;
          lo         <= lo_nx;
          hi         <= hi_nx;
          h_id       <= rd_id;
          h_dir      <= go_right;
          h_lc       <= n_lc;
          h_rc       <= n_rc;
          h_klo      <= n_klo;
          h_khi      <= n_khi;
          cur_sum    <= n_sum;
          cur_max    <= n_max;
          cur_min    <= n_min;
          if (child_sel != '0) begin
            cur   <= child_sel;
            state <= S_D_ISSUE;
          end else begin
            brk_lo <= lo_nx;
            brk_hi <= hi_nx;
            need   <= LVL_W'(1);
            state  <= S_COUNT;
          end
        end
        // count missing levels below the break
        S_COUNT: begin
          if (!leaf_w) begin
            lo   <= lo_nx;
            hi   <= hi_nx;
            need <= need + 1'b1;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (need != '0 && pool_full) begin
            busy      <= 1'b0;
            done      <= 1'b1;
            status    <= STATUS_FULL;
            range_sum <= '0;
            range_max <= '0;
            range_min <= '0;
            state     <= S_IDLE;
          end else if (need == '0) begin
            state <= S_L_ADD;
          end else begin
            lo    <= brk_lo;
            hi    <= brk_hi;
            state <= S_LINK;
          end
        end
        S_LINK: state <= S_ALLOC;
        // one new node per cycle down to the leaf
        S_ALLOC: begin
          nodes_used <= nodes_used + 1'b1;
          if (!leaf_w) begin
            path[pcur] <= k_id;
            pdir[pcur] <= go_right;
            len        <= len + 1'b1;
            lo         <= lo_nx;
            hi         <= hi_nx;
          end else begin
            cur_sum <= d64;
            cur_max <= d64;
            cur_min <= d64;
            state   <= S_U_ISSUE;
          end
        end
        S_L_ADD: begin
          cur_sum <= n_sum + d64;
          cur_max <= n_max + d64;
          cur_min <= n_min + d64;
          state   <= S_U_ISSUE;
        end
        S_U_ISSUE: begin
          if (len == '0) begin
            busy      <= 1'b0;
            done      <= 1'b1;
            status    <= STATUS_OK;
            range_sum <= '0;
            range_max <= '0;
            range_min <= '0;
            state     <= S_IDLE;
          end else begin
            state <= S_U_NODE;
          end
        end
        S_U_NODE: begin
          h_id  <= rd_id;
          h_lc  <= n_lc;
          h_rc  <= n_rc;
          h_klo <= n_klo;
          h_khi <= n_khi;
          if (other != '0) begin
            state <= S_U_SIB;
          end else begin
            cur_sum <= c_sum;
            cur_max <= c_max;
            cur_min <= c_min;
            len     <= len - 1'b1;
            state   <= S_U_ISSUE;
          end
        end
        S_U_SIB: begin
          cur_sum <= c_sum;
          cur_max <= c_max;
          cur_min <= c_min;
          len     <= len - 1'b1;
          state   <= S_U_ISSUE;
        end
        S_Q_POP: begin
          if (sp == '0) begin
            busy      <= 1'b0;
            done      <= 1'b1;
            status    <= STATUS_OK;
            range_sum <= acc_sum;
            range_max <= acc_max[62:0];
            range_min <= acc_min[62:0];
            state     <= S_IDLE;
          end else begin
            sp    <= sp - 1'b1;
            state <= S_Q_SRD;
          end
        end
        S_Q_SRD: state <= S_Q_EVAL;
        S_Q_EVAL: begin
          state <= S_Q_POP;
          if (!q_out && q_cov) begin
            acc_sum <= acc_sum + n_sum;
            if (n_max > acc_max) acc_max <= n_max;
            if (n_min < acc_min) acc_min <= n_min;
          end else if (q_split && (q_pl || q_pr)) begin
            sp   <= sp + 1'b1;
            pend <= n_rc;
            if (q_pl && q_pr) state <= S_Q_PUSH2;
          end
        end
        S_Q_PUSH2: begin
          sp    <= sp + 1'b1;
          state <= S_Q_POP;
        end
        default: state <= S_IDLE;
      endcase
      // range write empties the tree
      if (cfg_write) begin
        if (cfg_index == REG_RANGE_LOW) range_low <= cfg_data;
        else range_high <= cfg_data;
        nodes_used   <= CNT_W'(1);
        root_written <= 1'b0;
      end
    end
  end

  // Checks
  a_pool: assert property (@(posedge clk) disable iff (rst)
    (nodes_used >= CNT_W'(1)) && ({1'b0, nodes_used} <= POOL_LIM))
    else $error("node count out of range");
  a_path: assert property (@(posedge clk) disable iff (rst) len <= LVL_W'(LEVELS))
    else $error("path overflow");
  a_stack: assert property (@(posedge clk) disable iff (rst) sp <= SP_W'(STK_DEPTH))
    else $error("query stack overflow");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy) || $past(start))
    else $error("result without an item");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FULL) |-> $stable(nodes_used))
    else $error("dropped add changed the pool");

endmodule
